// ===== hdl/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, queue and output stage.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int WSFD_QDEPTH = 4;

	localparam logic [6:0]  LEN_EXT16     = 7'd126;
	localparam logic [6:0]  LEN_EXT64     = 7'd127;
	localparam logic [3:0]  OP_CONT       = 4'd0;
	localparam logic [3:0]  OP_CLOSE      = 4'd8;
	localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_KEY   = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  raw;
		logic [7:0]  key;
		logic        has_data;
		logic        last;
		logic [3:0]  opcode;
		logic        fin;
		logic [3:0]  msg_opcode;
		logic [63:0] length;
		logic        first;
		logic        second;
	} entry_t;

endpackage

// ===== hdl/websocket_frame_deframer_top.sv =====
// Input takes one byte per cycle unless the queue is full; header, extension and key
// bytes give no result. Results pass the entry queue, then the output register.
// The parser advances once per byte; output unmasks one byte per cycle unless stalled.
// A four-entry queue lets input continue while the output side is stalled.
// Reset: arst_n clears all parser, queue and output control state asynchronously.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Byte stream in, one result per payload byte or per empty frame out.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top import wsfd_pkg::*; #(
	parameter int QDEPTH = WSFD_QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// payload_byte[7:0], frame_opcode[11:8], final_fragment[12],
	// message_opcode[16:13], frame_length[80:17], close_code[96:81], zero pad
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tuser,   // has_data
	output logic         m_axis_tlast    // end_of_frame
);

	logic   push, pop, q_empty, q_full;
	entry_t push_entry, pop_entry;

	assign s_axis_tready = !q_full;

	wsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.push       (push),
		.push_entry (push_entry)
	);

	wsfd_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty),
		.full       (q_full)
	);

	wsfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (pop_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== hdl/wsfd_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer header parser
// Walks the frame header byte by byte and queues one entry per payload byte
// or per empty frame.
// ----------------------------------------------------------------------------
module wsfd_front import wsfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       push,
	output entry_t     push_entry
);

	phase_t      phase_q, phase_nx;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] length_q, length_nx;
	logic [2:0]  hcnt_q;
	logic [31:0] key_q;
	logic [63:0] remain_q;
	logic [1:0]  kidx_q;
	logic [1:0]  pcnt_q;
	logic [3:0]  frag_op_q;
	logic        acc;
	logic        start_data;
	logic        empty_ev;
	logic [7:0]  key_byte;
	logic        last_byte;

	assign acc = in_valid && in_ready;

	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign last_byte = (remain_q == 64'd1);

	always_comb begin
		phase_nx   = phase_q;
		length_nx  = length_q;
		start_data = 1'b0;
		empty_ev   = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				length_nx = 64'd0;
				if (in_byte[6:0] == LEN_EXT16) begin
					phase_nx = PH_EXT16;
				end else if (in_byte[6:0] == LEN_EXT64) begin
					phase_nx = PH_EXT64;
				end else begin
					length_nx = {57'd0, in_byte[6:0]};
					if (in_byte[7]) begin
						phase_nx = PH_KEY;
					end else begin
						start_data = 1'b1;
					end
				end
			end
			PH_EXT16, PH_EXT64: begin
				length_nx = {length_q[55:0], in_byte};
				if ((phase_q == PH_EXT16 && hcnt_q >= 3'd1) ||
				    (phase_q == PH_EXT64 && hcnt_q == 3'd7)) begin
					if (masked_q) begin
						phase_nx = PH_KEY;
					end else begin
						start_data = 1'b1;
					end
				end
			end
			PH_KEY: begin
				if (hcnt_q >= 3'd3) begin
					start_data = 1'b1;
				end
			end
			PH_DATA: begin
				if (last_byte) begin
					phase_nx = PH_HDR0;
				end
			end
			default: begin
				phase_nx = PH_HDR1;
			end
		endcase
		if (start_data) begin
			if (length_nx == 64'd0) begin
				phase_nx = PH_HDR0;
				empty_ev = 1'b1;
			end else begin
				phase_nx = PH_DATA;
			end
		end
	end

	assign push = acc && ((phase_q == PH_DATA) || empty_ev);

	always_comb begin
		push_entry            = '0;
		push_entry.opcode     = opcode_q;
		push_entry.fin        = fin_q;
		push_entry.msg_opcode = (opcode_q == OP_CONT) ? frag_op_q : opcode_q;
		push_entry.length     = length_nx;
		if (phase_q == PH_DATA) begin
			push_entry.raw      = in_byte;
			push_entry.key      = key_byte;
			push_entry.has_data = 1'b1;
			push_entry.last     = last_byte;
			push_entry.first    = (pcnt_q == 2'd0);
			push_entry.second   = (pcnt_q == 2'd1);
		end else begin
			push_entry.last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			fin_q     <= 1'b0;
			opcode_q  <= '0;
			masked_q  <= 1'b0;
			length_q  <= '0;
			hcnt_q    <= '0;
			key_q     <= '0;
			remain_q  <= '0;
			kidx_q    <= '0;
			pcnt_q    <= '0;
			frag_op_q <= '0;
		end else if (acc) begin
			phase_q  <= phase_nx;
			length_q <= length_nx;
			unique case (phase_q)
				PH_HDR1: begin
					masked_q <= in_byte[7];
					key_q    <= '0;
					hcnt_q   <= '0;
				end
				PH_EXT16, PH_EXT64: begin
					if (phase_nx != phase_q) begin
						hcnt_q <= '0;
					end else begin
						hcnt_q <= hcnt_q + 3'd1;
					end
				end
				PH_KEY: begin
					key_q  <= {key_q[23:0], in_byte};
					hcnt_q <= hcnt_q + 3'd1;
				end
				PH_DATA: begin
					remain_q <= remain_q - 64'd1;
					kidx_q   <= kidx_q + 2'd1;
					if (pcnt_q != 2'd2) begin
						pcnt_q <= pcnt_q + 2'd1;
					end
				end
				default: begin
					fin_q    <= in_byte[7];
					opcode_q <= in_byte[3:0];
					if (!in_byte[7] && in_byte[3:0] != OP_CONT && !in_byte[3]) begin
						frag_op_q <= in_byte[3:0];
					end
				end
			endcase
			if (start_data) begin
				remain_q <= length_nx;
				kidx_q   <= '0;
				pcnt_q   <= '0;
			end
		end
	end

endmodule

// ===== hdl/wsfd_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer entry queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsfd_queue import wsfd_pkg::*; #(
	parameter int QDEPTH = WSFD_QDEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   empty,
	output logic   full
);

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	entry_t          mem_q [QDEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(QDEPTH));
	assign pop_entry = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(QDEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(QDEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/wsfd_back.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Unmasks payload bytes, tracks the close status and holds the output
// register of the result stream.
// ----------------------------------------------------------------------------
module wsfd_back import wsfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  entry_t       q_entry,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [103:0] out_data,
	output logic         out_user,
	output logic         out_last
);

	logic         valid_q;
	logic [103:0] data_q;
	logic         user_q;
	logic         last_q;
	logic [7:0]   hi_q, lo_q;
	logic [7:0]   d;
	logic [7:0]   d_out;
	logic [15:0]  cc;

	assign pop = !q_empty && (!valid_q || out_ready);
	assign d   = q_entry.raw ^ q_entry.key;
	assign d_out = q_entry.has_data ? d : 8'd0;

	always_comb begin
		cc = 16'd0;
		if (q_entry.last && q_entry.opcode == OP_CLOSE) begin
			if (q_entry.length[63:1] == 63'd0) begin
				cc = CLOSE_DEFAULT;
			end else if (q_entry.second) begin
				cc = {hi_q, d};
			end else begin
				cc = {hi_q, lo_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {7'd0, cc, q_entry.length, q_entry.msg_opcode, q_entry.fin,
			           q_entry.opcode, d_out};
			user_q <= q_entry.has_data;
			last_q <= q_entry.last;
			if (q_entry.has_data && q_entry.first) begin
				hi_q <= d;
			end
			if (q_entry.has_data && q_entry.second) begin
				lo_q <= d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = last_q;

endmodule
